// ----- rtl/core/six_axis_moving_average_unit_assert.svh -----
// Assertion macros for the moving-average block.
// Both sample on the rising edge of clk and are held off while rst_n is low.
`ifndef SIX_AXIS_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define SIX_AXIS_MOVING_AVERAGE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle.
`define SAMAVG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SAMAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/samavg_pkg.sv -----
`default_nettype none

package samavg_pkg;

    localparam int AXIS_W             = 16;
    localparam int AXES               = 6;
    localparam int DEFAULT_WINDOW_LEN = 30;

    // Axis order: accel x, y, z, then gyro x, y, z.
    localparam int AX_ACCEL_X = 0;
    localparam int AX_ACCEL_Y = 1;
    localparam int AX_ACCEL_Z = 2;
    localparam int AX_GYRO_X  = 3;
    localparam int AX_GYRO_Y  = 4;
    localparam int AX_GYRO_Z  = 5;

    typedef logic [AXIS_W-1:0] axis_t;
    typedef axis_t [AXES-1:0]  sample_t;

    // Pipeline load enables handed to the divider lanes.
    typedef struct packed {
        logic load_mul;
        logic load_out;
    } div_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/samavg_ifs.sv -----
`default_nettype none

interface samavg_in_if
    import samavg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [AXIS_W-1:0] accel_x_in;
    logic [AXIS_W-1:0] accel_y_in;
    logic [AXIS_W-1:0] accel_z_in;
    logic [AXIS_W-1:0] gyro_x_in;
    logic [AXIS_W-1:0] gyro_y_in;
    logic [AXIS_W-1:0] gyro_z_in;

    modport source (
        output valid, accel_x_in, accel_y_in, accel_z_in, gyro_x_in, gyro_y_in, gyro_z_in,
        input  ready
    );
    modport sink (
        input  valid, accel_x_in, accel_y_in, accel_z_in, gyro_x_in, gyro_y_in, gyro_z_in,
        output ready
    );
endinterface

interface samavg_out_if
    import samavg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [AXIS_W-1:0] accel_x_avg;
    logic [AXIS_W-1:0] accel_y_avg;
    logic [AXIS_W-1:0] accel_z_avg;
    logic [AXIS_W-1:0] gyro_x_avg;
    logic [AXIS_W-1:0] gyro_y_avg;
    logic [AXIS_W-1:0] gyro_z_avg;

    modport source (
        output valid, accel_x_avg, accel_y_avg, accel_z_avg, gyro_x_avg, gyro_y_avg,
               gyro_z_avg,
        input  ready
    );
    modport sink (
        input  valid, accel_x_avg, accel_y_avg, accel_z_avg, gyro_x_avg, gyro_y_avg,
               gyro_z_avg,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/samavg_cell.sv -----
`default_nettype none

module samavg_cell
    import samavg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    shift_en,
    input  wire sample_t d,
    output sample_t      q
);

    sample_t sample_reg;
    sample_t sample_next;

    always_comb
    begin
        sample_next = shift_en ? d : sample_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    assign q = sample_reg;

endmodule

`default_nettype wire

// ----- rtl/core/samavg_div.sv -----
`default_nettype none

// Signed divide by WINDOW_LEN, truncating toward zero: magnitude times a
// reciprocal, then shift and restore the sign. Exact for every magnitude
// below 2**SUM_W.
module samavg_div
    import samavg_pkg::*;
#(
    parameter int WINDOW_LEN = DEFAULT_WINDOW_LEN
)
(
    input  wire logic                     clk,
    input  wire div_ctl_t                 ctl,
    input  wire logic signed [AXIS_W + $clog2(WINDOW_LEN) - 1:0] sum,
    output axis_t                         avg
);

    localparam int SUM_W  = AXIS_W + $clog2(WINDOW_LEN);
    localparam int SHIFT  = SUM_W + $clog2(WINDOW_LEN);
    localparam int PROD_W = 2 * SUM_W + 1;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];

    logic [SUM_W-1:0]  mag;
    logic [PROD_W-1:0] product_reg;
    logic [PROD_W-1:0] product_next;
    logic              neg_reg;
    logic              neg_next;
    axis_t             quot;
    axis_t             avg_reg;
    axis_t             avg_next;

    always_comb
    begin
        mag          = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        product_next = ctl.load_mul ? (PROD_W'(mag) * PROD_W'(RECIP)) : product_reg;
        neg_next     = ctl.load_mul ? sum[SUM_W-1] : neg_reg;
        quot         = product_reg[SHIFT +: AXIS_W];
        avg_next     = ctl.load_out ? (neg_reg ? AXIS_W'(-quot) : quot) : avg_reg;
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
        neg_reg     <= neg_next;
        avg_reg     <= avg_next;
    end

    assign avg = avg_reg;

endmodule

`default_nettype wire

// ----- rtl/core/six_axis_moving_average_unit.sv -----
// Channel   Dir  Handshake     Word
// sample    in   valid/ready   accel_x_in .. gyro_z_in, 6 x 16-bit signed
// average   out  valid/ready   accel_x_avg .. gyro_z_avg, 6 x 16-bit signed
//
// One word in per cycle, sustained while average.ready stays high. The path
// to a valid average: running sum registered at the accept edge, then
// reciprocal multiply, then output register.
// The window is a chain of WINDOW_LEN cells that shifts on each accept.
// rst_n clears the window, the sums and every valid flag at once.
// An output stall fills the three stages before sample.ready drops.
`default_nettype none

module six_axis_moving_average_unit
    import samavg_pkg::*;
#(
    parameter int WINDOW_LEN = DEFAULT_WINDOW_LEN
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    samavg_in_if.sink     sample,
    samavg_out_if.source  average
);

    localparam int SUM_W = AXIS_W + $clog2(WINDOW_LEN);

    sample_t  fresh;
    sample_t  chain [WINDOW_LEN+1];
    sample_t  tail;
    axis_t    avg [AXES];
    div_ctl_t ctl;

    logic signed [SUM_W-1:0] sum_reg  [AXES];
    logic signed [SUM_W-1:0] sum_next [AXES];

    logic accept;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        fresh[AX_ACCEL_X] = sample.accel_x_in;
        fresh[AX_ACCEL_Y] = sample.accel_y_in;
        fresh[AX_ACCEL_Z] = sample.accel_z_in;
        fresh[AX_GYRO_X]  = sample.gyro_x_in;
        fresh[AX_GYRO_Y]  = sample.gyro_y_in;
        fresh[AX_GYRO_Z]  = sample.gyro_z_in;
    end

    // Handshake: each stage can take a word when empty or when it drains.
    assign rdy3         = !out_valid_reg || average.ready;
    assign rdy2         = !s2_valid_reg || rdy3;
    assign rdy1         = !s1_valid_reg || rdy2;
    assign sample.ready = rdy1;
    assign accept       = sample.valid && rdy1;
    assign ctl.load_mul = rdy2;
    assign ctl.load_out = rdy3;

    // Window: cell 0 takes the new sample, the last cell holds the oldest.
    assign chain[0] = fresh;
    assign tail     = chain[WINDOW_LEN];

    for (genvar k = 0; k < WINDOW_LEN; k++)
    begin : g_cell
        samavg_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (accept),
            .d        (chain[k]),
            .q        (chain[k+1])
        );
    end

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            if (accept)
            begin
                sum_next[a] = sum_reg[a] + SUM_W'($signed(fresh[a])) - SUM_W'($signed(tail[a]));
            end
            else
            begin
                sum_next[a] = sum_reg[a];
            end
        end
        s1_valid_next  = accept ? 1'b1 : (rdy2 ? 1'b0 : s1_valid_reg);
        s2_valid_next  = rdy2 ? s1_valid_reg : s2_valid_reg;
        out_valid_next = rdy3 ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                sum_reg[a] <= '0;
            end
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int a = 0; a < AXES; a++)
            begin
                sum_reg[a] <= sum_next[a];
            end
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    for (genvar a = 0; a < AXES; a++)
    begin : g_div
        samavg_div #(
            .WINDOW_LEN (WINDOW_LEN)
        ) u_div (
            .clk (clk),
            .ctl (ctl),
            .sum (sum_reg[a]),
            .avg (avg[a])
        );
    end

    assign average.valid       = out_valid_reg;
    assign average.accel_x_avg = avg[AX_ACCEL_X];
    assign average.accel_y_avg = avg[AX_ACCEL_Y];
    assign average.accel_z_avg = avg[AX_ACCEL_Z];
    assign average.gyro_x_avg  = avg[AX_GYRO_X];
    assign average.gyro_y_avg  = avg[AX_GYRO_Y];
    assign average.gyro_z_avg  = avg[AX_GYRO_Z];

    `include "six_axis_moving_average_unit_assert.svh"

    `SAMAVG_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_reg, "accepted word lost")
    `SAMAVG_ASSERT_NEXT(a_sum_holds, !accept, $stable(sum_reg[AX_ACCEL_X]), "sum moved idle")
    `SAMAVG_ASSERT_NEXT(a_s2_holds, s2_valid_reg && !rdy3, s2_valid_reg, "stage 2 word dropped")
    `SAMAVG_ASSERT_NEXT(a_no_phantom, rdy3 && !s2_valid_reg, !out_valid_reg, "result invented")

endmodule

`default_nettype wire

// ----- sim/tb_six_axis_moving_average_unit.sv -----
`timescale 1ns / 1ps

module tb_six_axis_moving_average_unit;
    import samavg_pkg::*;

    localparam int WIN = DEFAULT_WINDOW_LEN;
    localparam int RANDOM_WORDS = 800;

    // Boxcar predictor plus the queue of averages still owed by the block.
    class boxcar_predictor;
        logic signed [AXIS_W-1:0] window [WIN][AXES];
        int                       slot;
        int                       sums [AXES];
        sample_t                  pending_avgs [$];
        int                       mismatch_count;
        string                    axis_name [AXES];

        function new();
            for (int i = 0; i < WIN; i++)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    window[i][a] = '0;
                end
            end
            for (int a = 0; a < AXES; a++)
            begin
                sums[a] = 0;
            end
            slot           = 0;
            mismatch_count = 0;
            axis_name[AX_ACCEL_X] = "accel_x_avg";
            axis_name[AX_ACCEL_Y] = "accel_y_avg";
            axis_name[AX_ACCEL_Z] = "accel_z_avg";
            axis_name[AX_GYRO_X]  = "gyro_x_avg";
            axis_name[AX_GYRO_Y]  = "gyro_y_avg";
            axis_name[AX_GYRO_Z]  = "gyro_z_avg";
        endfunction

        function void note_sample(sample_t s);
            sample_t avg_word;
            int      fresh;
            int      stale;
            int      avg;
            for (int a = 0; a < AXES; a++)
            begin
                fresh = $signed(s[a]);
                stale = window[slot][a];
                window[slot][a] = s[a];
                sums[a] = sums[a] + fresh - stale;
                // signed int division truncates toward zero
                avg = sums[a] / WIN;
                avg_word[a] = axis_t'(avg);
            end
            slot = (slot == WIN - 1) ? 0 : slot + 1;
            pending_avgs.push_back(avg_word);
        endfunction

        function void check_average(sample_t got);
            sample_t want;
            if (pending_avgs.size() == 0)
            begin
                mismatch_count++;
                $error("average word with nothing pending: %h", got);
                return;
            end
            want = pending_avgs.pop_front();
            for (int a = 0; a < AXES; a++)
            begin
                if (got[a] !== want[a])
                begin
                    mismatch_count++;
                    $error("%s: expected %0d, got %0d", axis_name[a],
                           $signed(want[a]), $signed(got[a]));
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic sink_hold;
    logic src_quiet;
    int   samples_sent;
    int   avgs_seen;

    boxcar_predictor boxcar = new();

    samavg_in_if  sample_ch ();
    samavg_out_if average_ch ();

    six_axis_moving_average_unit #(.WINDOW_LEN(WIN)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .average (average_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic sample_t make_sample(axis_t ax, axis_t ay, axis_t az,
                                            axis_t gx, axis_t gy, axis_t gz);
        sample_t s;
        s[AX_ACCEL_X] = ax;
        s[AX_ACCEL_Y] = ay;
        s[AX_ACCEL_Z] = az;
        s[AX_GYRO_X]  = gx;
        s[AX_GYRO_Y]  = gy;
        s[AX_GYRO_Z]  = gz;
        return s;
    endfunction

    // Offer one word after a random gap (zero while src_quiet), return once taken.
    task automatic send_sample(input sample_t s);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        repeat (gap)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.accel_x_in <= s[AX_ACCEL_X];
        sample_ch.accel_y_in <= s[AX_ACCEL_Y];
        sample_ch.accel_z_in <= s[AX_ACCEL_Z];
        sample_ch.gyro_x_in  <= s[AX_GYRO_X];
        sample_ch.gyro_y_in  <= s[AX_GYRO_Y];
        sample_ch.gyro_z_in  <= s[AX_GYRO_Z];
        do
            @(posedge clk);
        while (!sample_ch.ready);
        boxcar.note_sample(s);
        samples_sent++;
        src_quiet = ((samples_sent / 64) % 4) == 2;
    endtask

    // Result side: random stalls, a zero-stall stretch, and the long holds.
    initial
    begin : average_sink
        sample_t got;
        int      gap;
        average_ch.ready = 1'b0;
        avgs_seen = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = (((avgs_seen / 80) % 4) == 1) ? 0 : $urandom_range(0, 5);
            @(negedge clk);
            repeat (gap)
            begin
                average_ch.ready <= 1'b0;
                @(negedge clk);
            end
            while (sink_hold)
            begin
                average_ch.ready <= 1'b0;
                @(negedge clk);
            end
            average_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!average_ch.valid);
            got[AX_ACCEL_X] = average_ch.accel_x_avg;
            got[AX_ACCEL_Y] = average_ch.accel_y_avg;
            got[AX_ACCEL_Z] = average_ch.accel_z_avg;
            got[AX_GYRO_X]  = average_ch.gyro_x_avg;
            got[AX_GYRO_Y]  = average_ch.gyro_y_avg;
            got[AX_GYRO_Z]  = average_ch.gyro_z_avg;
            boxcar.check_average(got);
            avgs_seen++;
        end
    end

    // Long back-pressure spells so the pipeline fills and sample.ready drops.
    initial
    begin : hold_ctl
        sink_hold = 1'b0;
        wait (samples_sent >= 120);
        @(posedge clk);
        sink_hold = 1'b1;
        repeat (80) @(posedge clk);
        sink_hold = 1'b0;
        wait (samples_sent >= 500);
        @(posedge clk);
        sink_hold = 1'b1;
        repeat (50) @(posedge clk);
        sink_hold = 1'b0;
    end

    initial
    begin : watchdog
        #2000000;
        $display("tb_six_axis_moving_average_unit: errors");
        $finish;
    end

    initial
    begin : stimulus
        sample_t s;
        axis_t   base [AXES];
        int      kind;
        int      len;
        int      tmp;

        rst_n                = 1'b0;
        src_quiet            = 1'b0;
        samples_sent         = 0;
        sample_ch.valid      = 1'b0;
        sample_ch.accel_x_in = '0;
        sample_ch.accel_y_in = '0;
        sample_ch.accel_z_in = '0;
        sample_ch.gyro_x_in  = '0;
        sample_ch.gyro_y_in  = '0;
        sample_ch.gyro_z_in  = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes while the window still holds reset zeros,
        // -1 and +1 to check truncation toward zero.
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000,
                                16'h0000, 16'h0000, 16'h0000));
        send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF,
                                16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_sample(make_sample(16'h8000, 16'h8000, 16'h8000,
                                16'h8000, 16'h8000, 16'h8000));
        send_sample(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_sample(make_sample(16'h0001, 16'h0001, 16'h0001,
                                16'h0001, 16'h0001, 16'h0001));
        send_sample(make_sample(16'h7FFF, 16'h8000, 16'hFFFF,
                                16'h0001, 16'h5555, 16'hAAAA));
        send_sample(make_sample(16'hAAAA, 16'h5555, 16'h0001,
                                16'hFFFF, 16'h8000, 16'h7FFF));
        for (int i = 0; i < 18; i++)
        begin
            if (i % 2 == 0)
                s = make_sample(16'h7FFF, 16'h8000, 16'h7FFF,
                                16'h8000, 16'h7FFF, 16'h8000);
            else
                s = make_sample(16'h8000, 16'h7FFF, 16'h8000,
                                16'h7FFF, 16'h8000, 16'h7FFF);
            send_sample(s);
        end

        // Random segments; constant runs longer than the window reach the
        // full-scale averages, small values exercise rounding of negatives.
        while (samples_sent < RANDOM_WORDS + 25)
        begin
            kind = $urandom_range(0, 3);
            len  = $urandom_range(4, 70);
            for (int a = 0; a < AXES; a++)
            begin
                case ($urandom_range(0, 2))
                    0:       base[a] = 16'h7FFF;
                    1:       base[a] = 16'h8000;
                    default: base[a] = axis_t'($urandom);
                endcase
            end
            repeat (len)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    case (kind)
                        0: s[a] = axis_t'($urandom);
                        1: s[a] = base[a];
                        2:
                        begin
                            tmp  = int'($urandom_range(0, 40)) - 20;
                            s[a] = axis_t'(tmp);
                        end
                        default: s[a] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    endcase
                end
                send_sample(s);
            end
        end

        @(negedge clk);
        sample_ch.valid <= 1'b0;

        while (boxcar.pending_avgs.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (boxcar.pending_avgs.size() != 0)
        begin
            boxcar.mismatch_count++;
            $error("%0d averages never arrived", boxcar.pending_avgs.size());
        end

        if (boxcar.mismatch_count == 0)
            $display("tb_six_axis_moving_average_unit: clean");
        else
            $display("tb_six_axis_moving_average_unit: errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/samavg_pkg.sv
rtl/core/samavg_ifs.sv
rtl/core/samavg_cell.sv
rtl/core/samavg_div.sv
rtl/core/six_axis_moving_average_unit.sv
sim/tb_six_axis_moving_average_unit.sv
